/* sv/qte_pkg.sv */
package qte_pkg;

	localparam int W         = 40;
	localparam int ZW        = 34;
	localparam int TABLE_LEN = 30;
	localparam int FRONT_LAT = 2;
	localparam int ISQRT_LAT = 34;

	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1686629713;

	typedef struct packed {
		logic               has_quaternion;
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
	} qte_in_t;

	typedef struct packed {
		logic signed [14:0] pitch_centideg;
		logic signed [15:0] roll_centideg;
		logic signed [15:0] yaw_centideg;
	} qte_out_t;

	// atan(2^-i) in Q30 radians
	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			default: r = (i < TABLE_LEN) ? (32'd1 << (30 - i)) : 32'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/qte_front.sv */
module qte_front (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [31:0]         w,
	input  logic signed [31:0]         x,
	input  logic signed [31:0]         y,
	input  logic signed [31:0]         z,
	output logic signed [31:0]         s,
	output logic signed [qte_pkg::W-1:0] ry,
	output logic signed [qte_pkg::W-1:0] rx,
	output logic signed [qte_pkg::W-1:0] yy,
	output logic signed [qte_pkg::W-1:0] yx
);
	import qte_pkg::*;

	function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[63:30];
	endfunction

	function automatic logic signed [W-1:0] ext(input logic signed [33:0] v);
		return W'(v);
	endfunction

	logic signed [33:0] wy_s1, xz_s1, yz_s1, wx_s1, xx_s1, yy_s1, xy_s1, wz_s1, ww_s1, zz_s1;
	logic signed [W-1:0] s_raw;

	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= mul_q30(w, y);
			xz_s1 <= mul_q30(x, z);
			yz_s1 <= mul_q30(y, z);
			wx_s1 <= mul_q30(w, x);
			xx_s1 <= mul_q30(x, x);
			yy_s1 <= mul_q30(y, y);
			xy_s1 <= mul_q30(x, y);
			wz_s1 <= mul_q30(w, z);
			ww_s1 <= mul_q30(w, w);
			zz_s1 <= mul_q30(z, z);
		end
	end

	assign s_raw = (ext(wy_s1) - ext(xz_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (s_raw > W'(64'sd1073741824))
				s <= 32'sd1073741824;
			else if (s_raw < -W'(64'sd1073741824))
				s <= -32'sd1073741824;
			else
				s <= s_raw[31:0];
			ry <= (ext(yz_s1) + ext(wx_s1)) <<< 1;
			rx <= W'(64'sd1073741824) - ((ext(xx_s1) + ext(yy_s1)) <<< 1);
			yy <= (ext(xy_s1) + ext(wz_s1)) <<< 1;
			yx <= ext(ww_s1) + ext(xx_s1) - ext(yy_s1) - ext(zz_s1);
		end
	end

endmodule

/* sv/qte_isqrt.sv */
module qte_isqrt (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] s,
	output logic [30:0]        c
);
	import qte_pkg::*;

	localparam int STEPS = 32;

	logic [60:0] sq_s1;
	logic [63:0] rem_s [0:STEPS];
	logic [63:0] root_s [0:STEPS];
	logic signed [63:0] sq_full;

	assign sq_full = 64'(s) * 64'(s);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1     <= sq_full[60:0];
			rem_s[0]  <= 64'(61'h1000_0000_0000_0000 - sq_s1);
			root_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [63:0] trial;
		assign trial = root_s[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[i] >= trial) begin
					rem_s[i+1]  <= rem_s[i] - trial;
					root_s[i+1] <= (root_s[i] >> 1) + BIT;
				end else begin
					rem_s[i+1]  <= rem_s[i];
					root_s[i+1] <= root_s[i] >> 1;
				end
			end
		end
	end

	assign c = root_s[STEPS][30:0];

endmodule

/* sv/qte_cordic.sv */
module qte_cordic #(
	parameter int STEPS = 16,
	parameter int OW    = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [qte_pkg::W-1:0] y,
	input  logic signed [qte_pkg::W-1:0] x,
	output logic [OW-1:0]                angle
);
	import qte_pkg::*;

	logic signed [W-1:0]  x_s [0:STEPS];
	logic signed [W-1:0]  y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	logic                 zf_s [0:STEPS];
	logic signed [47:0]   prod;

	// quarter turn into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				if (y >= 0) begin
					x_s[0] <= y;
					y_s[0] <= -x;
					z_s[0] <= QUARTER_TURN;
				end else begin
					x_s[0] <= -y;
					y_s[0] <= x;
					z_s[0] <= -QUARTER_TURN;
				end
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN = $signed({2'b00, atan_step(i)});
		logic signed [W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN;
				end
			end
		end
	end

	// centidegrees, round half up
	assign prod = (zf_s[STEPS] ? 48'sd0 : 48'(z_s[STEPS])) * 48'sd5730 + (48'sd1 <<< 29);

	always_ff @(posedge clk) begin
		if (en)
			angle <= prod[OW+29:30];
	end

endmodule

/* sv/quaternion_to_euler_angles.sv */
// The 34-stage integer square root lies ahead of the CORDIC stages.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Items with has_quaternion clear are taken and produce no result.
// arst_n clears the valid bits only; data registers are not reset.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              quat_valid,
	output logic              quat_stall,
	input  qte_pkg::qte_in_t  quat,
	output logic              angles_valid,
	input  logic              angles_stall,
	output qte_pkg::qte_out_t angles
);
	import qte_pkg::*;

	localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int LAT    = FRONT_LAT + ISQRT_LAT + NSTEPS + 2;

	typedef struct packed {
		logic signed [31:0]  s;
		logic signed [W-1:0] ry;
		logic signed [W-1:0] rx;
		logic signed [W-1:0] yy;
		logic signed [W-1:0] yx;
	} qte_vec_t;

	logic           en;
	logic [LAT-1:0] vld_q;
	qte_vec_t       front;
	qte_vec_t       dl_s [0:ISQRT_LAT];
	logic [30:0]    c;
	logic [14:0]    pitch;
	logic [15:0]    roll, yaw;

	assign en         = !(angles_valid && angles_stall);
	assign quat_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], quat_valid && quat.has_quaternion};
	end

	assign angles_valid = vld_q[LAT-1];

	qte_front u_front (
		.clk (clk),
		.en  (en),
		.w   (quat.quat_w),
		.x   (quat.quat_x),
		.y   (quat.quat_y),
		.z   (quat.quat_z),
		.s   (front.s),
		.ry  (front.ry),
		.rx  (front.rx),
		.yy  (front.yy),
		.yx  (front.yx)
	);

	qte_isqrt u_isqrt (
		.clk (clk),
		.en  (en),
		.s   (front.s),
		.c   (c)
	);

	assign dl_s[0] = front;

	for (genvar i = 0; i < ISQRT_LAT; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en)
				dl_s[i+1] <= dl_s[i];
		end
	end

	qte_cordic #(.STEPS(NSTEPS), .OW(15)) u_pitch (
		.clk   (clk),
		.en    (en),
		.y     (W'(dl_s[ISQRT_LAT].s)),
		.x     ({{(W-31){1'b0}}, c}),
		.angle (pitch)
	);

	qte_cordic #(.STEPS(NSTEPS), .OW(16)) u_roll (
		.clk   (clk),
		.en    (en),
		.y     (dl_s[ISQRT_LAT].ry),
		.x     (dl_s[ISQRT_LAT].rx),
		.angle (roll)
	);

	qte_cordic #(.STEPS(NSTEPS), .OW(16)) u_yaw (
		.clk   (clk),
		.en    (en),
		.y     (dl_s[ISQRT_LAT].yy),
		.x     (dl_s[ISQRT_LAT].yx),
		.angle (yaw)
	);

	assign angles.pitch_centideg = pitch;
	assign angles.roll_centideg  = roll;
	assign angles.yaw_centideg   = yaw;

`ifndef NO_ASSERTIONS
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> (angles.pitch_centideg >= -15'sd9001 &&
			angles.pitch_centideg <= 15'sd9001))
		else $error("pitch out of range");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> (angles.roll_centideg >= -16'sd18002 &&
			angles.roll_centideg <= 16'sd18002 && angles.yaw_centideg >= -16'sd18002 &&
			angles.yaw_centideg <= 16'sd18002))
		else $error("roll or yaw out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(angles_valid && angles_stall) |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(quat_valid && !quat_stall && !quat.has_quaternion) |=> !vld_q[0])
		else $error("item without quaternion entered");
`endif

endmodule
